>>> sv/ssps_pkg.sv
// Shared types and constants for the state-space plant step block.
`timescale 1ns / 1ps
package ssps_pkg;
    localparam logic [1:0] OP_LOAD_COEF  = 2'd0;
    localparam logic [1:0] OP_LOAD_STATE = 2'd1;
    localparam logic [1:0] OP_STEP       = 2'd2;
    localparam logic [1:0] OP_EVAL       = 2'd3;

    localparam logic [16:0] FRICTION_RESET = 17'd6554;
    localparam logic [47:0] TIME_MAX       = 48'hFFFF_FFFF_FFFF;
    localparam int          VEL_IDX_0      = 1;
    localparam int          VEL_IDX_1      = 3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         load_index;
        logic signed [31:0] load_value;
        logic signed [31:0] drive_0;
        logic signed [31:0] drive_1;
        logic [30:0]        time_step;
        logic               friction_enable;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] measure_0;
        logic signed [31:0] measure_1;
        logic [47:0]        elapsed_time;
    } t_out_word;

    // Control handed to the MAC along with each operand.
    typedef struct packed {
        logic       vld;   // operand on the bus is live
        logic       clr;   // first term of a dot product
        logic       last;  // last term: round and retire
    } t_mac_ctl;

    // Round to nearest (ties up) from exact Q48.32 sum, add bias, saturate.
    function automatic logic signed [31:0] round_sat(input logic signed [79:0] acc,
                                                    input logic signed [18:0] bias);
        logic signed [80:0] r;
        logic signed [64:0] q;
        begin
            r = {acc[79], acc} + 81'sd32768;
            q = r[80:16] + {{46{bias[18]}}, bias};
            if (q > 65'sh0_7FFF_FFFF)       round_sat = 32'sh7FFF_FFFF;
            else if (q < -65'sh0_8000_0000) round_sat = 32'sh8000_0000;
            else                            round_sat = q[31:0];
        end
    endfunction
endpackage

>>> sv/ssps_cell.sv
// One state cell: holds one state element and shifts it to its neighbor.
`timescale 1ns / 1ps
module ssps_cell (
    input  logic               i_clk,
    input  logic               i_shift,
    input  logic               i_load,
    input  logic signed [31:0] i_load_value,
    input  logic signed [31:0] i_prev,
    output logic signed [31:0] o_value
);
    logic signed [31:0] r_value;
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_load_value;
        end else if (i_shift) begin
            r_value <= i_prev;
        end
    end
    assign o_value = r_value;
endmodule

>>> sv/ssps_mac.sv
// Shared multiply-accumulate unit with registered product.
`timescale 1ns / 1ps
module ssps_mac (
    input  logic                        i_clk,
    input  ssps_pkg::t_mac_ctl          i_ctl,
    input  logic signed [31:0]          i_a,
    input  logic signed [31:0]          i_b,
    output logic                        o_done,
    output logic signed [79:0]          o_acc
);
    logic signed [63:0] r_prod;
    ssps_pkg::t_mac_ctl r_ctl;
    logic signed [79:0] r_acc;
    logic               r_done;
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_ctl  <= i_ctl;
        r_done <= r_ctl.vld & r_ctl.last;
        if (r_ctl.vld) begin
            r_acc <= (r_ctl.clr ? 80'sd0 : r_acc) + {{16{r_prod[63]}}, r_prod};
        end
    end
    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule

>>> sv/state_space_plant_step.sv
// Top level: discrete linear plant emulator, x = Ax + Bu, y = Cx + Du.
//
// channel  direction  handshake                        payload
// in       input      i_in_valid / o_in_ready          t_in_word
// out      output     o_out_valid / i_out_ready        t_out_word
// cfg      input      i_cfg_we (always taken)          friction mu, 17 bits
//
// Loads: a load word is decoded and written in S_NEXT before the next word is taken.
// Step: S_NEXT decodes the word, then for each of the N state rows and M measure
// rows ISSUE streams the N+D terms into the MAC and WAIT drains it, and S_OUT
// hands the result to the output register. Evaluate runs only the M measure rows.
// In ISSUE the state rotates through a ring of cells, one element per cycle, into
// the single shared MAC; the coefficient memory port gives one term per cycle.
// Reset clears control, time and the state; the coefficient store is cleared by
// a sweep over all DEPTH addresses after reset, during which no word is taken.
// The result sits in an output register; the next word is still taken, and a
// finished result waits in S_OUT until that register frees up.
`timescale 1ns / 1ps
module state_space_plant_step #(
    parameter int STATE_COUNT   = 6,
    parameter int DRIVE_COUNT   = 2,
    parameter int MEASURE_COUNT = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ssps_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ssps_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_we,
    input  logic [16:0]          i_cfg_data
);
    localparam int OFS_B = STATE_COUNT * STATE_COUNT;
    localparam int OFS_C = OFS_B + STATE_COUNT * DRIVE_COUNT;
    localparam int OFS_D = OFS_C + MEASURE_COUNT * STATE_COUNT;
    localparam int DEPTH = OFS_D + MEASURE_COUNT * DRIVE_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = STATE_COUNT + MEASURE_COUNT;
    localparam int TERMS = STATE_COUNT + DRIVE_COUNT;
    localparam int RW    = $clog2(ROWS + 1);
    localparam int TW    = $clog2(TERMS + 1);
    localparam int SW    = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int MW    = (MEASURE_COUNT > 1) ? $clog2(MEASURE_COUNT) : 1;
    localparam bit VEL_OK0 = ssps_pkg::VEL_IDX_0 < STATE_COUNT;
    localparam bit VEL_OK1 = ssps_pkg::VEL_IDX_1 < STATE_COUNT;

    // One-hot sequencer.
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ISSUE = 6'b000100,
        S_WAIT  = 6'b001000,
        S_NEXT  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    logic [16:0]   r_mu;
    logic [47:0]   r_time;
    ssps_pkg::t_in_word r_item;
    logic [RW-1:0] r_row;      // 0..N-1 state rows, N.. measure rows
    logic [TW-1:0] r_term;
    logic          r_out_valid;
    ssps_pkg::t_out_word r_out;
    logic signed [31:0] r_nx [STATE_COUNT];
    logic signed [31:0] r_y  [MEASURE_COUNT];

    // Coefficient memory.
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_coef;
    logic [AW-1:0]      mem_raddr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_coef <= r_mem[mem_raddr];
    end

    // State ring of cells; element 0 feeds the MAC.
    logic signed [31:0] cell_q [STATE_COUNT];
    logic               ring_shift;
    logic               ring_commit;
    logic               ring_zero;
    logic               st_load;
    logic signed [31:0] row_res;   // rounded result of the row now retiring
    for (genvar g = 0; g < STATE_COUNT; g++) begin : g_cell
        logic        ld;
        logic signed [31:0] ldv;
        assign ld  = ring_zero || ring_commit ||
                     (st_load && r_item.load_index == 6'(g));
        // last state row retires in the commit cycle itself
        assign ldv = ring_zero ? 32'sd0 :
                     (ring_commit ? ((g == STATE_COUNT - 1) ? row_res : r_nx[g])
                                  : r_item.load_value);
        ssps_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (ring_shift),
            .i_load      (ld),
            .i_load_value(ldv),
            .i_prev      (cell_q[(g + 1) % STATE_COUNT]),
            .o_value     (cell_q[g])
        );
    end

    // Operand for the current term, aligned with the registered memory read.
    logic signed [31:0] drv_sel;
    always_comb begin
        drv_sel = 32'sd0;
        if (r_term == TW'(STATE_COUNT)) drv_sel = r_item.drive_0;
        else if (DRIVE_COUNT > 1 && r_term == TW'(STATE_COUNT + 1)) drv_sel = r_item.drive_1;
    end
    logic signed [31:0] r_opnd;
    ssps_pkg::t_mac_ctl r_ctl, n_ctl;
    logic               mac_done;
    logic signed [79:0] mac_acc;

    ssps_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (r_ctl),
        .i_a   (r_coef),
        .i_b   (r_opnd),
        .o_done(mac_done),
        .o_acc (mac_acc)
    );

    // Address of the coefficient for (row, term).
    always_comb begin
        int a;
        a = 0;
        if (r_row < RW'(STATE_COUNT)) begin
            if (r_term < TW'(STATE_COUNT)) a = int'(r_row) * STATE_COUNT + int'(r_term);
            else a = OFS_B + int'(r_row) * DRIVE_COUNT + int'(r_term) - STATE_COUNT;
        end else begin
            if (r_term < TW'(STATE_COUNT))
                a = OFS_C + (int'(r_row) - STATE_COUNT) * STATE_COUNT + int'(r_term);
            else a = OFS_D + (int'(r_row) - STATE_COUNT) * DRIVE_COUNT
                     + int'(r_term) - STATE_COUNT;
        end
        mem_raddr = AW'(a);
    end

    // Output register is loaded when the result is done and the slot is free.
    logic in_acc, out_acc, out_load;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_out_valid && i_out_ready;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || out_acc);

    logic is_step;
    assign is_step = (r_item.opcode == ssps_pkg::OP_STEP);

    // Friction bias for the current state row, from the pre-update state.
    logic signed [18:0] bias;
    always_comb begin
        logic signed [31:0] xv;
        logic               hit;
        xv  = 32'sd0;
        hit = 1'b0;
        if (VEL_OK0 && r_row == RW'(ssps_pkg::VEL_IDX_0)) begin
            hit = 1'b1; xv = cell_q[SW'(ssps_pkg::VEL_IDX_0 % STATE_COUNT)];
        end
        if (VEL_OK1 && r_row == RW'(ssps_pkg::VEL_IDX_1)) begin
            hit = 1'b1; xv = cell_q[SW'(ssps_pkg::VEL_IDX_1 % STATE_COUNT)];
        end
        bias = 19'sd0;
        if (hit && is_step && r_item.friction_enable) begin
            if (xv > 0)      bias = -$signed({2'b00, r_mu});
            else if (xv < 0) bias = $signed({2'b00, r_mu});
        end
    end

    assign row_res = ssps_pkg::round_sat(mac_acc, bias);

    logic [48:0] time_sum;
    assign time_sum = {1'b0, r_time} + {18'd0, r_item.time_step};

    // Sequencer: ISSUE streams TERMS operands of one row; WAIT drains the MAC;
    // the ring has rotated fully back, so cell 0 is x[0] again at each row.
    always_comb begin
        n_state     = r_state;
        n_ctl       = '0;
        ring_shift  = 1'b0;
        ring_commit = 1'b0;
        ring_zero   = !i_rst_n;
        st_load     = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_clr_addr;
        mem_wdata   = 32'sd0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) n_state = S_NEXT;
            end
            S_NEXT: begin
                priority if (r_item.opcode == ssps_pkg::OP_LOAD_COEF) begin
                    mem_we    = (int'(r_item.load_index) < DEPTH);
                    mem_waddr = AW'(r_item.load_index);
                    mem_wdata = r_item.load_value;
                    n_state   = S_IDLE;
                end else if (r_item.opcode == ssps_pkg::OP_LOAD_STATE) begin
                    st_load = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_ctl.vld  = 1'b1;
                n_ctl.clr  = (r_term == '0);
                n_ctl.last = (r_term == TW'(TERMS - 1));
                if (r_term < TW'(STATE_COUNT)) ring_shift = 1'b1;
                if (r_term == TW'(TERMS - 1)) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (mac_done) begin
                    if (r_row == RW'(STATE_COUNT - 1) && is_step) ring_commit = 1'b1;
                    if (r_row == RW'(ROWS - 1)) n_state = S_OUT;
                    else n_state = S_ISSUE;
                end
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_mu        <= ssps_pkg::FRICTION_RESET;
            r_time      <= '0;
            r_out_valid <= 1'b0;
            r_ctl       <= '0;
            r_row       <= '0;
            r_term      <= '0;
        end else begin
            r_state <= n_state;
            r_ctl   <= n_ctl;
            if (i_cfg_we) r_mu <= i_cfg_data;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (out_load) r_out_valid <= 1'b1;
            else if (out_acc) r_out_valid <= 1'b0;
            if (r_state == S_NEXT) begin
                r_term <= '0;
                r_row  <= is_step ? '0 : RW'(STATE_COUNT);
            end
            if (r_state == S_ISSUE) begin
                r_term <= (r_term == TW'(TERMS - 1)) ? '0 : r_term + TW'(1);
            end
            if (r_state == S_WAIT && mac_done) begin
                r_row <= r_row + RW'(1);
                if (r_row == RW'(STATE_COUNT - 1) && is_step) begin
                    r_time <= time_sum[48] ? ssps_pkg::TIME_MAX : time_sum[47:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_item <= i_in_word;
        r_opnd <= (r_term < TW'(STATE_COUNT)) ? cell_q[0] : drv_sel;
        if (r_state == S_WAIT && mac_done) begin
            if (r_row < RW'(STATE_COUNT)) r_nx[SW'(r_row)] <= row_res;
            else r_y[MW'(r_row - RW'(STATE_COUNT))] <= ssps_pkg::round_sat(mac_acc, 19'sd0);
        end
        if (out_load) begin
            r_out.measure_0    <= r_y[0];
            r_out.measure_1    <= (MEASURE_COUNT > 1) ? r_y[MW'(1)] : 32'sd0;
            r_out.elapsed_time <= r_time;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
endmodule
